### rtl/core/atmb_pkg.sv
// Package for the affine transform matrix builder: constants, types and the
// CORDIC arctangent table. No dependencies.
`default_nettype none
package atmb_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_COUNT   = 24;

    localparam logic signed [31:0] Q_ONE       = 32'sd65536;
    localparam logic signed [31:0] Q_TWO_PI    = 32'sd411775;
    localparam logic signed [31:0] Q_PI        = 32'sd205887;
    localparam logic signed [31:0] Q_HALF_PI   = 32'sd102944;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    typedef enum logic [1:0] {
        OP_TRANSLATE = 2'd0,
        OP_SCALE     = 2'd1,
        OP_ROTATE    = 2'd2,
        OP_NONE      = 2'd3
    } t_op;

    typedef logic signed [31:0] t_q;

    // Arctangent of 2^-i in Q2.30.
    function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
        logic signed [33:0] v;
        unique case (i)
            5'd0:  v = 34'sd843314856;
            5'd1:  v = 34'sd497837829;
            5'd2:  v = 34'sd263043836;
            5'd3:  v = 34'sd133525158;
            5'd4:  v = 34'sd67021686;
            5'd5:  v = 34'sd33543515;
            5'd6:  v = 34'sd16775850;
            5'd7:  v = 34'sd8388437;
            5'd8:  v = 34'sd4194282;
            5'd9:  v = 34'sd2097149;
            5'd10: v = 34'sd1048575;
            5'd11: v = 34'sd524287;
            5'd12: v = 34'sd262143;
            5'd13: v = 34'sd131071;
            5'd14: v = 34'sd65535;
            5'd15: v = 34'sd32767;
            5'd16: v = 34'sd16383;
            5'd17: v = 34'sd8191;
            5'd18: v = 34'sd4095;
            5'd19: v = 34'sd2047;
            5'd20: v = 34'sd1023;
            5'd21: v = 34'sd511;
            5'd22: v = 34'sd255;
            5'd23: v = 34'sd127;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction

    // Saturate a wide signed value to 32 bits.
    function automatic t_q sat32(input logic signed [65:0] v);
        t_q r;
        if (v > 66'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -66'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Q16.16 product: exact, floor shift by 16, saturate.
    function automatic t_q mulq(input t_q a, input t_q b);
        logic signed [63:0] p;
        logic signed [65:0] w;
        p = a * b;
        w = 66'(p);
        return sat32(w >>> 16);
    endfunction

endpackage
`default_nettype wire

### rtl/core/atmb_sincos.sv
// Pipelined sine/cosine: angle reduction mod 2*pi, quadrant fold, one
// register stage per CORDIC step, rounding. Depends on atmb_pkg.
`default_nettype none
module atmb_sincos (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_valid,
    input  atmb_pkg::t_q     i_angle,
    output logic             o_valid,
    output atmb_pkg::t_q     o_cos,
    output atmb_pkg::t_q     o_sin
);
    localparam int NS = atmb_pkg::CORDIC_STEPS;
    localparam int QBITS = 14; // quotient of 2^31/411775 < 2^13

    // Stage A: reduction quotient via reciprocal multiply (floor of |a|/2pi est.)
    logic        r_a_valid;
    logic signed [31:0] r_a_ang;
    logic [QBITS-1:0]   r_a_q;
    logic [31:0] w_abs;
    logic [63:0] w_qprod;
    assign w_abs   = i_angle[31] ? (~i_angle + 32'd1) : i_angle;
    // 2^45 / 411775 = 85445624.x, floor gives underestimate by at most one
    assign w_qprod = {32'd0, w_abs} * 64'd85445624;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
        end
        if (i_en) begin
            r_a_ang <= i_angle;
            r_a_q   <= w_qprod[45 +: QBITS];
        end
    end

    // Stage B: remainder of |a|, correct once, sign, move to (-pi,pi], fold
    logic [31:0] w_absb, w_rem0, w_rem1;
    logic signed [33:0] w_r, w_r2, w_r3;
    logic        w_flip;
    assign w_absb = r_a_ang[31] ? (~r_a_ang + 32'd1) : r_a_ang;
    assign w_rem0 = w_absb - 32'(r_a_q * 32'd411775);
    assign w_rem1 = (w_rem0 >= 32'd411775) ? w_rem0 - 32'd411775 : w_rem0;
    always_comb begin
        w_r = r_a_ang[31] ? -$signed({2'b00, w_rem1}) : $signed({2'b00, w_rem1});
        if (w_r < 0) w_r2 = w_r + 34'(atmb_pkg::Q_TWO_PI);
        else w_r2 = w_r;
        if (w_r2 > 34'(atmb_pkg::Q_PI)) w_r2 = w_r2 - 34'(atmb_pkg::Q_TWO_PI);
        w_flip = 1'b0;
        w_r3 = w_r2;
        if (w_r2 > 34'(atmb_pkg::Q_HALF_PI)) begin
            w_r3 = w_r2 - 34'(atmb_pkg::Q_PI);
            w_flip = 1'b1;
        end else if (w_r2 < -34'(atmb_pkg::Q_HALF_PI)) begin
            w_r3 = w_r2 + 34'(atmb_pkg::Q_PI);
            w_flip = 1'b1;
        end
    end

    // CORDIC stages; entry 0 is the stage B register
    logic               r_c_valid [NS+1];
    logic               r_c_flip  [NS+1];
    logic signed [33:0] r_c_x     [NS+1];
    logic signed [33:0] r_c_y     [NS+1];
    logic signed [33:0] r_c_z     [NS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_c_valid[0] <= r_a_valid;
        end
        if (i_en) begin
            r_c_flip[0] <= w_flip;
            r_c_x[0]    <= atmb_pkg::CORDIC_GAIN;
            r_c_y[0]    <= 34'sd0;
            r_c_z[0]    <= w_r3 <<< 14;
        end
    end

    for (genvar g = 0; g < NS; g++) begin : g_cordic
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_c_valid[g+1] <= 1'b0;
            end else if (i_en) begin
                r_c_valid[g+1] <= r_c_valid[g];
            end
            if (i_en) begin
                r_c_flip[g+1] <= r_c_flip[g];
                if (r_c_z[g] >= 0) begin
                    r_c_x[g+1] <= r_c_x[g] - (r_c_y[g] >>> g);
                    r_c_y[g+1] <= r_c_y[g] + (r_c_x[g] >>> g);
                    r_c_z[g+1] <= r_c_z[g] - atmb_pkg::atan_q30(5'(g));
                end else begin
                    r_c_x[g+1] <= r_c_x[g] + (r_c_y[g] >>> g);
                    r_c_y[g+1] <= r_c_y[g] - (r_c_x[g] >>> g);
                    r_c_z[g+1] <= r_c_z[g] + atmb_pkg::atan_q30(5'(g));
                end
            end
        end
    end

    // Output stage: round half up to Q16.16, apply flip
    logic signed [33:0] w_xr, w_yr;
    assign w_xr = (r_c_x[NS] + 34'sd8192) >>> 14;
    assign w_yr = (r_c_y[NS] + 34'sd8192) >>> 14;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_c_valid[NS];
        end
        if (i_en) begin
            o_cos <= r_c_flip[NS] ? -w_xr[31:0] : w_xr[31:0];
            o_sin <= r_c_flip[NS] ? -w_yr[31:0] : w_yr[31:0];
        end
    end
endmodule
`default_nettype wire

### rtl/core/affine_transform_matrix_builder.sv
// Top level of the affine transform matrix builder: input pipeline, matrix
// arithmetic and row serialiser. Depends on atmb_pkg and atmb_sincos.
`default_nettype none
// Each request (op on tuser, p0..p3 Q16.16 on tdata) yields a 4x4 homogeneous
// matrix as four row results, row 0 first, tlast on row 3. Translate fills
// column 3, scale the diagonal, rotate the axis-angle matrix from a
// CORDIC_STEPS deep CORDIC pipeline; every entry saturates to Q16.16. The
// datapath is a fully pipelined chain (reduction, CORDIC stages, two product
// stages, sum into the serialiser); the whole chain advances only while the
// row serialiser can take a matrix. The serialiser holds one finished matrix
// and emits it row by row, taking the next matrix on the cycle its last row
// leaves, so one request is taken per matrix sent: the single output channel
// sets that rate.
module affine_transform_matrix_builder (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // tuser: op[1:0]
    input  wire logic [1:0]   s_axis_tuser,
    // tdata: p0[31:0], p1[63:32], p2[95:64], p3[127:96]
    input  wire logic [127:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // tdata: row[1:0], col0[33:2], col1[65:34], col2[97:66], col3[129:98], pad
    output logic [135:0]      m_axis_tdata,
    output logic              m_axis_tlast
);
    typedef atmb_pkg::t_q t_q;

    logic w_en;          // advance the whole pipeline
    logic r_o_full;      // serialiser holds a matrix
    logic [1:0] r_o_row;
    logic w_o_take;

    // Sin/cos pipeline; side data travels through a matching delay line.
    localparam int SC_LAT = atmb_pkg::CORDIC_STEPS + 3;
    logic w_sc_valid;
    t_q   w_cos, w_sin;
    logic s_in_acc;
    assign s_axis_tready = w_en;
    assign s_in_acc = s_axis_tvalid & s_axis_tready;

    atmb_sincos u_sincos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (s_in_acc),
        .i_angle (s_axis_tdata[31:0]),
        .o_valid (w_sc_valid),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    typedef struct packed {
        logic [1:0] op;
        t_q p0, p1, p2, p3;
    } t_side;

    t_side r_side [SC_LAT];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0] <= t_side'{s_axis_tuser, s_axis_tdata[31:0],
                s_axis_tdata[63:32], s_axis_tdata[95:64], s_axis_tdata[127:96]};
            for (int k = 1; k < SC_LAT; k++) r_side[k] <= r_side[k-1];
        end
    end

    // Stage P1: first products (pairs of axis components, axis * sin)
    logic r1_valid;
    t_side r1_side;
    t_q r1_c, r1_omc;
    t_q r1_xx, r1_xy, r1_xz, r1_yy, r1_yz, r1_zz, r1_xs, r1_ys, r1_zs;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_en) begin
            r1_valid <= w_sc_valid;
        end
        if (w_en) begin
            r1_side <= r_side[SC_LAT-1];
            r1_c    <= w_cos;
            r1_omc  <= atmb_pkg::Q_ONE - w_cos;
            r1_xx <= atmb_pkg::mulq(r_side[SC_LAT-1].p1, r_side[SC_LAT-1].p1);
            r1_xy <= atmb_pkg::mulq(r_side[SC_LAT-1].p1, r_side[SC_LAT-1].p2);
            r1_xz <= atmb_pkg::mulq(r_side[SC_LAT-1].p1, r_side[SC_LAT-1].p3);
            r1_yy <= atmb_pkg::mulq(r_side[SC_LAT-1].p2, r_side[SC_LAT-1].p2);
            r1_yz <= atmb_pkg::mulq(r_side[SC_LAT-1].p2, r_side[SC_LAT-1].p3);
            r1_zz <= atmb_pkg::mulq(r_side[SC_LAT-1].p3, r_side[SC_LAT-1].p3);
            r1_xs <= atmb_pkg::mulq(r_side[SC_LAT-1].p1, w_sin);
            r1_ys <= atmb_pkg::mulq(r_side[SC_LAT-1].p2, w_sin);
            r1_zs <= atmb_pkg::mulq(r_side[SC_LAT-1].p3, w_sin);
        end
    end

    // Stage P2: multiply by (1 - c)
    logic r2_valid;
    t_side r2_side;
    t_q r2_c, r2_xx, r2_xy, r2_xz, r2_yy, r2_yz, r2_zz, r2_xs, r2_ys, r2_zs;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (w_en) begin
            r2_valid <= r1_valid;
        end
        if (w_en) begin
            r2_side <= r1_side;
            r2_c    <= r1_c;
            r2_xx <= atmb_pkg::mulq(r1_xx, r1_omc);
            r2_xy <= atmb_pkg::mulq(r1_xy, r1_omc);
            r2_xz <= atmb_pkg::mulq(r1_xz, r1_omc);
            r2_yy <= atmb_pkg::mulq(r1_yy, r1_omc);
            r2_yz <= atmb_pkg::mulq(r1_yz, r1_omc);
            r2_zz <= atmb_pkg::mulq(r1_zz, r1_omc);
            r2_xs <= r1_xs;
            r2_ys <= r1_ys;
            r2_zs <= r1_zs;
        end
    end

    // Stage S: sums, saturate, select matrix by op
    function automatic t_q add_sat(input t_q a, input t_q b, input logic sub);
        logic signed [65:0] s;
        s = sub ? (66'(a) - 66'(b)) : (66'(a) + 66'(b));
        return atmb_pkg::sat32(s);
    endfunction

    t_q w_m [4][4];
    always_comb begin
        for (int r = 0; r < 4; r++)
            for (int k = 0; k < 4; k++)
                w_m[r][k] = (r == k) ? atmb_pkg::Q_ONE : 32'sd0;
        unique case (atmb_pkg::t_op'(r2_side.op))
            atmb_pkg::OP_TRANSLATE: begin
                w_m[0][3] = r2_side.p0;
                w_m[1][3] = r2_side.p1;
                w_m[2][3] = r2_side.p2;
            end
            atmb_pkg::OP_SCALE: begin
                w_m[0][0] = r2_side.p0;
                w_m[1][1] = r2_side.p1;
                w_m[2][2] = r2_side.p2;
            end
            atmb_pkg::OP_ROTATE: begin
                w_m[0][0] = add_sat(r2_xx, r2_c, 1'b0);
                w_m[0][1] = add_sat(r2_xy, r2_zs, 1'b1);
                w_m[0][2] = add_sat(r2_xz, r2_ys, 1'b0);
                w_m[1][0] = add_sat(r2_xy, r2_zs, 1'b0);
                w_m[1][1] = add_sat(r2_yy, r2_c, 1'b0);
                w_m[1][2] = add_sat(r2_yz, r2_xs, 1'b1);
                w_m[2][0] = add_sat(r2_xz, r2_ys, 1'b1);
                w_m[2][1] = add_sat(r2_yz, r2_xs, 1'b0);
                w_m[2][2] = add_sat(r2_zz, r2_c, 1'b0);
            end
            atmb_pkg::OP_NONE: begin
            end
            default: begin
            end
        endcase
    end

    // Row serialiser: hold one matrix, drop it row by row
    t_q r_o_m [4][4];
    assign w_o_take = m_axis_tvalid & m_axis_tready;
    // Advance when the serialiser is empty or its last row leaves now.
    assign w_en = !r_o_full || (w_o_take && (r_o_row == 2'd3));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_full <= 1'b0;
            r_o_row  <= 2'd0;
        end else begin
            if (w_o_take) r_o_row <= r_o_row + 2'd1;
            if (w_en) r_o_full <= r2_valid;
        end
        if (w_en && r2_valid) r_o_m <= w_m;
    end

    assign m_axis_tvalid = r_o_full;
    assign m_axis_tlast  = (r_o_row == 2'd3);
    assign m_axis_tdata  = {6'd0, r_o_m[r_o_row][3], r_o_m[r_o_row][2],
                            r_o_m[r_o_row][1], r_o_m[r_o_row][0], r_o_row};

`ifndef SYNTH
    // Row counter only moves while a matrix is held.
    a_row_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_o_full |-> r_o_row == 2'd0) else $error("row counter moved while empty");
    // Input accepted only when the pipeline advances.
    a_acc_en: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_in_acc |-> w_en) else $error("request taken while stalled");
    // After the last row leaves with nothing behind it, the output empties.
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_o_take && m_axis_tlast && !r2_valid) |=> !m_axis_tvalid)
        else $error("matrix repeated");
`endif
endmodule
`default_nettype wire
